>>> sv/sis_pkg.sv
// Shared types and constants for the software interrupt scheduler.
// Used by sis_ctrl, sis_datapath and software_interrupt_scheduler_core.
package sis_pkg;

    localparam int ID_W      = 7;
    localparam int PRIO_IN_W = 6;
    localparam int OP_W      = 2;
    localparam int ST_W      = 3;
    localparam int MAX_SWI_ID = 99;

    localparam logic [OP_W-1:0] OP_CREATE   = 2'd0;
    localparam logic [OP_W-1:0] OP_ACTIVATE = 2'd1;
    localparam logic [OP_W-1:0] OP_DONE     = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR    = 2'd3;

    localparam logic [ST_W-1:0] ST_OK         = 3'd0;
    localparam logic [ST_W-1:0] ST_BAD_ARGS   = 3'd1;
    localparam logic [ST_W-1:0] ST_EXISTS     = 3'd2;
    localparam logic [ST_W-1:0] ST_NOT_CREATE = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL       = 3'd4;
    localparam logic [ST_W-1:0] ST_NONE_RUN   = 3'd5;

    typedef struct packed {
        logic            load;
        logic            create;
        logic            append;
        logic            scan_min;
        logic            scan_id;
        logic            scan_shift;
        logic            dec_count;
        logic            pop;
        logic            drop;
        logic            dispatch;
        logic            clear;
        logic            emit;
        logic [ST_W-1:0] res;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            bad;
        logic            created;
        logic            full;
        logic            running;
        logic            busy;
        logic            found;
        logic            should;
        logic            stack_full;
        logic            out_free;
    } t_stat;

endpackage

>>> sv/sis_ctrl.sv
// Controller state machine of the software interrupt scheduler.
// Depends on sis_pkg; drives sis_datapath through t_cmd and reads t_stat.
module sis_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  sis_pkg::t_stat i_stat,
    output sis_pkg::t_cmd  o_cmd
);
    import sis_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DEC, S_SCAN_ID, S_SHIFT, S_POP, S_SCAN_TOP, S_DISP, S_OUT
    } t_state;

    t_state          r_state, n_state;
    logic [ST_W-1:0] r_res, n_res;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        o_cmd   = '0;
        o_cmd.res = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                n_res   = ST_OK;
                n_state = S_OUT;
                unique case (i_stat.op)
                    OP_CREATE: begin
                        if (i_stat.bad) begin
                            n_res = ST_BAD_ARGS;
                        end else if (i_stat.created) begin
                            n_res = ST_EXISTS;
                        end else begin
                            o_cmd.create = 1'b1;
                        end
                    end
                    OP_ACTIVATE: begin
                        if (!i_stat.created) begin
                            n_res = ST_NOT_CREATE;
                        end else if (i_stat.full) begin
                            n_res = ST_FULL;
                        end else begin
                            o_cmd.append   = 1'b1;
                            o_cmd.scan_min = 1'b1;
                            n_state        = S_SCAN_TOP;
                        end
                    end
                    OP_DONE: begin
                        if (!i_stat.running) begin
                            n_res = ST_NONE_RUN;
                        end else begin
                            o_cmd.scan_id = 1'b1;
                            n_state       = S_SCAN_ID;
                        end
                    end
                    default: begin
                        o_cmd.clear = 1'b1;
                    end
                endcase
            end
            S_SCAN_ID: begin
                if (!i_stat.busy) begin
                    if (i_stat.found) begin
                        o_cmd.scan_shift = 1'b1;
                        n_state          = S_SHIFT;
                    end else begin
                        n_state = S_POP;
                    end
                end
            end
            S_SHIFT: begin
                if (!i_stat.busy) begin
                    o_cmd.dec_count = 1'b1;
                    n_state         = S_POP;
                end
            end
            S_POP: begin
                o_cmd.pop      = 1'b1;
                o_cmd.scan_min = 1'b1;
                n_state        = S_SCAN_TOP;
            end
            S_SCAN_TOP: begin
                if (!i_stat.busy) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_OUT;
                if (i_stat.should) begin
                    if (i_stat.op == OP_ACTIVATE && i_stat.running && i_stat.stack_full) begin
                        o_cmd.drop = 1'b1;
                        n_res      = ST_FULL;
                    end else begin
                        o_cmd.dispatch = 1'b1;
                    end
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_res   <= ST_OK;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
        end
    end

endmodule

>>> sv/sis_datapath.sv
// Datapath of the software interrupt scheduler: tables, pending set, nesting
// stack, scan engine and output register. Depends on sis_pkg.
module sis_datapath #(
    parameter int NUM_SWI     = 128,
    parameter int PRIO_LEVELS = 32,
    parameter int QUEUE_DEPTH = 32,
    parameter int STACK_DEPTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sis_pkg::t_cmd                i_cmd,
    output sis_pkg::t_stat               o_stat,
    input  logic [sis_pkg::OP_W-1:0]      i_in_op,
    input  logic [sis_pkg::ID_W-1:0]      i_in_id,
    input  logic [sis_pkg::PRIO_IN_W-1:0] i_in_prio,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [sis_pkg::ST_W-1:0]      o_out_status,
    output logic                         o_out_dv,
    output logic [sis_pkg::ID_W-1:0]      o_out_id
);
    import sis_pkg::*;

    localparam int IW  = $clog2(NUM_SWI);
    localparam int PW  = $clog2(PRIO_LEVELS);
    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SCW = $clog2(STACK_DEPTH + 1);
    localparam int EW  = ID_W + PW;

    typedef enum logic [1:0] {M_MIN, M_ID, M_SHIFT} t_mode;

    logic [OP_W-1:0]      r_op;
    logic [ID_W-1:0]      r_id;
    logic [PRIO_IN_W-1:0] r_pr;
    logic [NUM_SWI-1:0]   r_created;
    logic [PW-1:0]        prio_mem [NUM_SWI];
    logic [PW-1:0]        r_tab_rd;
    logic [EW-1:0]        pend_mem [QUEUE_DEPTH];
    logic [EW-1:0]        r_pend_rd;
    logic [QCW-1:0]       r_pcnt;
    logic [EW-1:0]        stk_mem [STACK_DEPTH];
    logic [EW-1:0]        r_stk_rd;
    logic [SCW-1:0]       r_depth;
    logic [ID_W-1:0]      r_run_id;
    logic [PW-1:0]        r_run_prio;
    logic                 r_running;
    logic                 r_busy;
    t_mode                r_mode;
    logic [QCW-1:0]       r_idx;
    logic                 r_rv;
    logic [QAW-1:0]       r_ridx;
    logic                 r_found;
    logic [QAW-1:0]       r_best_idx;
    logic [ID_W-1:0]      r_best_id;
    logic [PW-1:0]        r_best_prio;
    logic                 r_dv;
    logic [ID_W-1:0]      r_did;
    logic                 r_ovalid;
    logic [ST_W-1:0]      r_ostatus;
    logic                 r_odv;
    logic [ID_W-1:0]      r_odid;

    logic            issue;
    logic            in_range;
    logic            stk_full;
    logic [ID_W-1:0] rd_id;
    logic [PW-1:0]   rd_prio;

    assign issue    = r_busy && (r_idx < r_pcnt);
    assign in_range = 32'(r_id) < NUM_SWI;
    assign stk_full = r_depth >= SCW'(STACK_DEPTH);
    assign rd_id    = r_pend_rd[EW-1:PW];
    assign rd_prio  = r_pend_rd[PW-1:0];

    always_comb begin
        o_stat.op         = r_op;
        o_stat.bad        = (r_id > ID_W'(MAX_SWI_ID)) || !in_range
                            || (32'(r_pr) >= PRIO_LEVELS);
        o_stat.created    = in_range && r_created[IW'(r_id)];
        o_stat.full       = r_pcnt >= QCW'(QUEUE_DEPTH);
        o_stat.running    = r_running;
        o_stat.busy       = r_busy;
        o_stat.found      = r_found;
        o_stat.should     = r_found && (!r_running || (r_best_prio < r_run_prio));
        o_stat.stack_full = stk_full;
        o_stat.out_free   = !r_ovalid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.create) begin
            prio_mem[IW'(r_id)] <= PW'(r_pr);
        end
        r_tab_rd <= prio_mem[IW'(i_in_id)];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            pend_mem[QAW'(r_pcnt)] <= {r_id, r_tab_rd};
        end else if (r_busy && r_mode == M_SHIFT && r_rv) begin
            pend_mem[r_ridx - QAW'(1)] <= r_pend_rd;
        end
        r_pend_rd <= pend_mem[QAW'(r_idx)];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.dispatch && r_running && !stk_full) begin
            stk_mem[SAW'(r_depth)] <= {r_run_id, r_run_prio};
        end
        r_stk_rd <= stk_mem[SAW'(r_depth - SCW'(1))];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_created <= '0;
            r_pcnt    <= '0;
            r_depth   <= '0;
            r_running <= 1'b0;
            r_run_id  <= '0;
            r_busy    <= 1'b0;
            r_rv      <= 1'b0;
            r_found   <= 1'b0;
            r_ovalid  <= 1'b0;
            r_mode    <= M_MIN;
        end else begin
            if (i_cmd.load) begin
                r_op  <= i_in_op;
                r_id  <= i_in_id;
                r_pr  <= i_in_prio;
                r_dv  <= 1'b0;
                r_did <= '0;
            end
            if (i_cmd.create) begin
                r_created[IW'(r_id)] <= 1'b1;
            end
            if (i_cmd.append) begin
                r_pcnt <= r_pcnt + QCW'(1);
            end
            if (i_cmd.dec_count || i_cmd.drop) begin
                r_pcnt <= r_pcnt - QCW'(1);
            end

            if (i_cmd.scan_min || i_cmd.scan_id || i_cmd.scan_shift) begin
                r_busy <= 1'b1;
                r_rv   <= 1'b0;
                if (i_cmd.scan_shift) begin
                    r_mode <= M_SHIFT;
                    r_idx  <= QCW'(r_best_idx) + QCW'(1);
                end else begin
                    r_mode  <= i_cmd.scan_id ? M_ID : M_MIN;
                    r_idx   <= '0;
                    r_found <= 1'b0;
                end
            end else if (r_busy) begin
                if (issue) begin
                    r_idx  <= r_idx + QCW'(1);
                    r_rv   <= 1'b1;
                    r_ridx <= QAW'(r_idx);
                end else begin
                    r_rv <= 1'b0;
                    if (!r_rv) begin
                        r_busy <= 1'b0;
                    end
                end
                if (r_rv) begin
                    case (r_mode)
                        M_MIN: begin
                            if (!r_found || rd_prio < r_best_prio) begin
                                r_found     <= 1'b1;
                                r_best_idx  <= r_ridx;
                                r_best_id   <= rd_id;
                                r_best_prio <= rd_prio;
                            end
                        end
                        M_ID: begin
                            if (!r_found && rd_id == r_run_id) begin
                                r_found    <= 1'b1;
                                r_best_idx <= r_ridx;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            if (i_cmd.pop) begin
                if (r_depth != '0) begin
                    r_depth    <= r_depth - SCW'(1);
                    r_run_id   <= r_stk_rd[EW-1:PW];
                    r_run_prio <= r_stk_rd[PW-1:0];
                end else begin
                    r_running <= 1'b0;
                    r_run_id  <= '0;
                end
            end

            if (i_cmd.dispatch) begin
                if (r_running && !stk_full) begin
                    r_depth <= r_depth + SCW'(1);
                end
                r_run_id   <= r_best_id;
                r_run_prio <= r_best_prio;
                r_running  <= 1'b1;
                r_dv       <= 1'b1;
                r_did      <= r_best_id;
            end

            if (i_cmd.clear) begin
                r_created <= '0;
                r_pcnt    <= '0;
                r_depth   <= '0;
                r_running <= 1'b0;
                r_run_id  <= '0;
            end

            if (i_cmd.emit) begin
                r_ovalid  <= 1'b1;
                r_ostatus <= i_cmd.res;
                r_odv     <= r_dv;
                r_odid    <= r_did;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_out_status = r_ostatus;
    assign o_out_dv     = r_odv;
    assign o_out_id     = r_odid;

endmodule

>>> sv/software_interrupt_scheduler_core.sv
// Software interrupt scheduler, top level: sis_ctrl plus sis_datapath, uses sis_pkg.
// One item at a time. The pending set is scanned one entry a cycle through its
// read port.
// Synchronous active-low reset clears flags, counts and run state; the tables
// need no clearing pass.
module software_interrupt_scheduler_core #(
    parameter int NUM_SWI     = 128,
    parameter int PRIO_LEVELS = 32,
    parameter int QUEUE_DEPTH = 32,
    parameter int STACK_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,  // swi_id[6:0], prio[12:7], zero pad
    input  logic [1:0]  i_s_tuser,  // op[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,  // status[2:0], dispatch_id[9:3], zero pad
    output logic        o_m_tuser   // dispatch_valid
);
    import sis_pkg::*;

    t_cmd            cmd;
    t_stat           stat;
    logic [ST_W-1:0] out_status;
    logic [ID_W-1:0] out_id;

    sis_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sis_datapath #(
        .NUM_SWI     (NUM_SWI),
        .PRIO_LEVELS (PRIO_LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_in_op      (i_s_tuser),
        .i_in_id      (i_s_tdata[6:0]),
        .i_in_prio    (i_s_tdata[12:7]),
        .o_out_valid  (o_m_tvalid),
        .i_out_ready  (i_m_tready),
        .o_out_status (out_status),
        .o_out_dv     (o_m_tuser),
        .o_out_id     (out_id)
    );

    assign o_m_tdata = {6'd0, out_id, out_status};

    a_dispatch_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata[2:0] == ST_OK)
        else $error("dispatch with non-ok status");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !stat.busy)
        else $error("scan active while accepting");

    a_no_id_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[9:3] == '0)
        else $error("dispatch id without dispatch");

endmodule

>>> dv/tb.sv
// Self-checking testbench for software_interrupt_scheduler_core.
// Predicts each output beat in a scoreboard class and drives both stream sides
// with random idling; depends on sis_pkg and the core only.
`timescale 1ns / 1ps

module tb;
    import sis_pkg::*;

    typedef struct packed {
        logic [ST_W-1:0] status;
        logic            dv;
        logic [ID_W-1:0] did;
    } t_dispatch;

    class sis_scoreboard;
        bit              created[128];
        logic [4:0]      prio_tab[128];
        logic [ID_W-1:0] pend_id[$];
        logic [4:0]      pend_pr[$];
        logic [ID_W-1:0] nest[$];
        logic [ID_W-1:0] run_id;
        bit              running;
        int              n_created;
        int              errors;
        t_dispatch       expq[$];

        function void wipe();
            foreach (created[k]) created[k] = 0;
            pend_id.delete();
            pend_pr.delete();
            nest.delete();
            run_id = '0;
            running = 0;
            n_created = 0;
        endfunction

        function int most_urgent();
            int best;
            best = -1;
            foreach (pend_pr[k])
                if (best < 0 || pend_pr[k] < pend_pr[best]) best = k;
            return best;
        endfunction

        function bit outranks(int t);
            if (t < 0) return 0;
            if (!running) return 1;
            return pend_pr[t] < prio_tab[run_id];
        endfunction

        function void start_handler(int t);
            if (running && nest.size() < 32) nest.push_back(run_id);
            run_id = pend_id[t];
            running = 1;
        endfunction

        function void note_input(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                 logic [PRIO_IN_W-1:0] pr);
            t_dispatch e;
            int t;
            e = '0;
            case (op)
                OP_CREATE: begin
                    if (id > MAX_SWI_ID || pr >= 32) e.status = ST_BAD_ARGS;
                    else if (created[id]) e.status = ST_EXISTS;
                    else begin
                        created[id] = 1;
                        prio_tab[id] = pr[4:0];
                        n_created++;
                    end
                end
                OP_ACTIVATE: begin
                    if (!created[id]) e.status = ST_NOT_CREATE;
                    else if (pend_id.size() >= 32) e.status = ST_FULL;
                    else begin
                        pend_id.push_back(id);
                        pend_pr.push_back(prio_tab[id]);
                        t = most_urgent();
                        if (outranks(t)) begin
                            if (running && nest.size() >= 32) begin
                                void'(pend_id.pop_back());
                                void'(pend_pr.pop_back());
                                e.status = ST_FULL;
                            end else begin
                                start_handler(t);
                                e.dv = 1;
                                e.did = run_id;
                            end
                        end
                    end
                end
                OP_DONE: begin
                    if (!running) e.status = ST_NONE_RUN;
                    else begin
                        foreach (pend_id[k])
                            if (pend_id[k] == run_id) begin
                                pend_id.delete(k);
                                pend_pr.delete(k);
                                break;
                            end
                        if (nest.size() > 0) run_id = nest.pop_back();
                        else begin
                            run_id = '0;
                            running = 0;
                        end
                        t = most_urgent();
                        if (outranks(t)) begin
                            start_handler(t);
                            e.dv = 1;
                            e.did = run_id;
                        end
                    end
                end
                default: wipe();
            endcase
            expq.push_back(e);
        endfunction

        function void check_result(t_dispatch got);
            t_dispatch e;
            if (expq.size() == 0) begin
                $display("%0t: unexpected beat, actual %h", $realtime, got);
                errors++;
                return;
            end
            e = expq.pop_front();
            if (got.status !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $realtime, e.status, got.status);
                errors++;
            end
            if (got.dv !== e.dv) begin
                $display("%0t: dispatch_valid expected %0d actual %0d", $realtime, e.dv, got.dv);
                errors++;
            end
            if (got.did !== e.did) begin
                $display("%0t: dispatch_id expected %0d actual %0d", $realtime, e.did, got.did);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;  // swi_id[6:0], prio[12:7], zero pad
    logic [1:0]  s_tuser;  // op[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;  // status[2:0], dispatch_id[9:3], zero pad
    logic        m_tuser;  // dispatch_valid

    sis_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int recv_hold;

    software_interrupt_scheduler_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

    task automatic send(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                        logic [PRIO_IN_W-1:0] pr);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b0, pr, id};
        do @(posedge i_clk); while (!s_tready);
        sb.note_input(op, id, pr);
    endtask

    task automatic send_random();
        int r;
        logic [ID_W-1:0] id;
        r = $urandom_range(99);
        if (sb.n_created < 6 && r < 60) r = 95;
        id = ID_W'($urandom_range(127));
        if (r < 1) send(OP_CLEAR, ID_W'($urandom), PRIO_IN_W'($urandom));
        else if (r < 56) begin
            for (int k = 0; k < 20 && !sb.created[id]; k++) id = ID_W'($urandom_range(127));
            send(OP_ACTIVATE, id, PRIO_IN_W'($urandom));
        end else if (r < 86) send(OP_DONE, ID_W'($urandom), PRIO_IN_W'($urandom));
        else if (r < 90) send(OP_CREATE, ID_W'($urandom), PRIO_IN_W'($urandom));
        else send(OP_CREATE, ID_W'($urandom_range(MAX_SWI_ID)), PRIO_IN_W'($urandom_range(31)));
    endtask

    // receive side
    initial begin
        m_tready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (recv_hold > 0) begin
                m_tready <= 1'b0;
                recv_hold--;
            end else m_tready <= ($urandom_range(99) >= recv_stall_pct);
            @(posedge i_clk);
            if (m_tvalid && m_tready) sb.check_result({m_tdata[2:0], m_tuser, m_tdata[9:3]});
        end
    end

    initial begin
        sb = new();
        sb.wipe();
        sb.errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        recv_hold = 0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_CLEAR;
        i_rst_n  <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        @(posedge i_clk);

        send(OP_CREATE, 7'd5, 6'd10);
        send(OP_CREATE, 7'd5, 6'd3);
        send(OP_CREATE, 7'd100, 6'd1);
        send(OP_CREATE, 7'd127, 6'd63);
        send(OP_CREATE, 7'd0, 6'd32);
        send(OP_CREATE, 7'd99, 6'd31);
        send(OP_CREATE, 7'd1, 6'd0);
        send(OP_CREATE, 7'd2, 6'd10);
        send(OP_DONE, 7'd0, 6'd0);
        send(OP_ACTIVATE, 7'd50, 6'd0);
        send(OP_ACTIVATE, 7'd127, 6'd0);
        send(OP_ACTIVATE, 7'd5, 6'd0);
        send(OP_ACTIVATE, 7'd2, 6'd0);
        send(OP_ACTIVATE, 7'd1, 6'd0);
        send(OP_ACTIVATE, 7'd1, 6'd0);
        send(OP_ACTIVATE, 7'd99, 6'd0);
        repeat (5) send(OP_DONE, 7'd0, 6'd0);
        send(OP_CLEAR, 7'd127, 6'd63);
        send(OP_DONE, 7'd0, 6'd0);
        send(OP_CREATE, 7'd7, 6'd31);
        repeat (34) send(OP_ACTIVATE, 7'd7, 6'd0);
        send(OP_CLEAR, 7'd0, 6'd0);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct  = (ph == 0) ? 18 : (ph == 1) ? 67 : 0;
            recv_stall_pct = (ph == 0) ? 67 : (ph == 1) ? 18 : 0;
            for (int n = 0; n < 600; n++) begin
                if (ph == 0 && n == 300) recv_hold = 400;
                if (ph == 1 && n == 300) begin
                    s_tvalid <= 1'b0;
                    @(posedge i_clk);
                    while (sb.expq.size() != 0) @(posedge i_clk);
                end
                send_random();
            end
        end
        s_tvalid <= 1'b0;

        for (int k = 0; k < 200000 && sb.expq.size() != 0; k++) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.expq.size() == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

endmodule

>>> files.f
sv/sis_pkg.sv
sv/sis_ctrl.sv
sv/sis_datapath.sv
sv/software_interrupt_scheduler_core.sv
dv/tb.sv
